// ===== hw/rtl/cfu_pkg.sv =====
// shared types, constants and arithmetic helpers for the cpml cell update unit
package cfu_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int PROD_WIDTH = 64;
   localparam int WIDE_WIDTH = 67;
   localparam int KT_WIDTH   = 36;

   localparam logic [4:0] COEF_SHIFT  = 5'd30;
   localparam logic [4:0] FIELD_SHIFT = 5'd24;

   localparam logic signed [DATA_WIDTH-1:0] Q_ONE = 32'sh0100_0000;
   localparam logic signed [DATA_WIDTH-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_WIDTH-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CSR_E_SCALE = 2'd0,
      CSR_H_SCALE = 2'd1,
      CSR_E_STEP  = 2'd2,
      CSR_H_STEP  = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_H_UPDATE = 1'b0,
      FUNC_E_UPDATE = 1'b1
   } func_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] e_scale;
      logic signed [DATA_WIDTH-1:0] h_scale;
      logic signed [DATA_WIDTH-1:0] e_step;
      logic signed [DATA_WIDTH-1:0] h_step;
   } cfg_type;

   typedef struct packed {
      logic                         func;
      logic signed [DATA_WIDTH-1:0] old_value;
      logic signed [DATA_WIDTH-1:0] curl_first;
      logic signed [DATA_WIDTH-1:0] curl_second;
      logic signed [DATA_WIDTH-1:0] psi_first;
      logic signed [DATA_WIDTH-1:0] psi_second;
      logic signed [DATA_WIDTH-1:0] decay_first;
      logic signed [DATA_WIDTH-1:0] gain_first;
      logic signed [DATA_WIDTH-1:0] decay_second;
      logic signed [DATA_WIDTH-1:0] gain_second;
      logic signed [DATA_WIDTH-1:0] inv_kappa_first;
      logic signed [DATA_WIDTH-1:0] inv_kappa_second;
   } req_type;

   typedef struct packed {
      logic                         is_e;
      logic signed [DATA_WIDTH-1:0] step;
      logic signed [PROD_WIDTH-1:0] old_prod;
      logic signed [PROD_WIDTH-1:0] bp1;
      logic signed [PROD_WIDTH-1:0] cc1;
      logic signed [PROD_WIDTH-1:0] bp2;
      logic signed [PROD_WIDTH-1:0] cc2;
      logic signed [PROD_WIDTH-1:0] ck1;
      logic signed [PROD_WIDTH-1:0] ck2;
   } prod_type;

   typedef struct packed {
      logic                         is_e;
      logic signed [DATA_WIDTH-1:0] step;
      logic signed [PROD_WIDTH-1:0] old_prod;
      logic signed [DATA_WIDTH-1:0] inner;
      logic signed [DATA_WIDTH-1:0] np1;
      logic signed [DATA_WIDTH-1:0] np2;
   } inner_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] new_value;
      logic signed [DATA_WIDTH-1:0] new_psi_first;
      logic signed [DATA_WIDTH-1:0] new_psi_second;
   } rsp_type;

   // round half up of (p1 +/- p2) / 2^shift, exact
   function automatic logic signed [WIDE_WIDTH-1:0] round_sum(
      input logic signed [PROD_WIDTH-1:0] p1,
      input logic signed [PROD_WIDTH-1:0] p2,
      input logic                         sub,
      input logic [4:0]                   shift
   );
      logic signed [WIDE_WIDTH-1:0] a;
      logic signed [WIDE_WIDTH-1:0] b;
      logic signed [WIDE_WIDTH-1:0] s;
      logic signed [WIDE_WIDTH-1:0] half;
      a    = {{(WIDE_WIDTH-PROD_WIDTH){p1[PROD_WIDTH-1]}}, p1};
      b    = {{(WIDE_WIDTH-PROD_WIDTH){p2[PROD_WIDTH-1]}}, p2};
      half = {{(WIDE_WIDTH-1){1'b0}}, 1'b1} << (shift - 5'd1);
      s    = sub ? (a - b) : (a + b);
      s    = s + half;
      return s >>> shift;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_q(
      input logic signed [WIDE_WIDTH-1:0] v
   );
      logic signed [WIDE_WIDTH-1:0] hi;
      logic signed [WIDE_WIDTH-1:0] lo;
      hi = {{(WIDE_WIDTH-DATA_WIDTH){Q_MAX[DATA_WIDTH-1]}}, Q_MAX};
      lo = {{(WIDE_WIDTH-DATA_WIDTH){Q_MIN[DATA_WIDTH-1]}}, Q_MIN};
      if (v > hi) begin
         return Q_MAX;
      end else if (v < lo) begin
         return Q_MIN;
      end
      return v[DATA_WIDTH-1:0];
   endfunction

endpackage

// ===== hw/rtl/cfu_csr_regs.sv =====
// scale and step registers with their plain write port
module cfu_csr_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [cfu_pkg::DATA_WIDTH-1:0]     csr_wdata,
   output cfu_pkg::cfg_type                   cfg
);

   cfu_pkg::cfg_type cfg_ff;
   cfu_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (cfu_pkg::csr_index_type'(csr_index))
            cfu_pkg::CSR_E_SCALE: cfg_in.e_scale = csr_wdata;
            cfu_pkg::CSR_H_SCALE: cfg_in.h_scale = csr_wdata;
            cfu_pkg::CSR_E_STEP:  cfg_in.e_step  = csr_wdata;
            cfu_pkg::CSR_H_STEP:  cfg_in.h_step  = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.e_scale <= cfu_pkg::Q_ONE;
         cfg_ff.h_scale <= cfu_pkg::Q_ONE;
         cfg_ff.e_step  <= cfu_pkg::Q_ONE;
         cfg_ff.h_step  <= cfu_pkg::Q_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/cfu_product_stage.sv =====
// first pipeline stage: all seven 32x32 products, registered
module cfu_product_stage (
   input  logic               clock,
   input  logic               reset,
   input  cfu_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  cfu_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output cfu_pkg::prod_type  out_data
);

   logic              v1_ff;
   logic              v1_in;
   cfu_pkg::prod_type prod_ff;
   cfu_pkg::prod_type prod_in;
   logic signed [cfu_pkg::DATA_WIDTH-1:0] scale;

   assign in_ready = !v1_ff || out_ready;

   always_comb begin
      v1_in   = v1_ff;
      prod_in = prod_ff;
      scale   = (in_data.func == cfu_pkg::FUNC_E_UPDATE) ? cfg.e_scale : cfg.h_scale;
      if (in_ready) begin
         v1_in = in_valid;
      end
      if (in_ready && in_valid) begin
         prod_in.is_e     = (in_data.func == cfu_pkg::FUNC_E_UPDATE);
         prod_in.step     = (in_data.func == cfu_pkg::FUNC_E_UPDATE) ? cfg.e_step : cfg.h_step;
         prod_in.old_prod = $signed(scale) * $signed(in_data.old_value);
         prod_in.bp1      = $signed(in_data.decay_first) * $signed(in_data.psi_first);
         prod_in.cc1      = $signed(in_data.gain_first) * $signed(in_data.curl_first);
         prod_in.bp2      = $signed(in_data.decay_second) * $signed(in_data.psi_second);
         prod_in.cc2      = $signed(in_data.gain_second) * $signed(in_data.curl_second);
         prod_in.ck1      = $signed(in_data.curl_first) * $signed(in_data.inv_kappa_first);
         prod_in.ck2      = $signed(in_data.curl_second) * $signed(in_data.inv_kappa_second);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      prod_ff <= prod_in;
   end

   assign out_valid = v1_ff;
   assign out_data  = prod_ff;

endmodule

// ===== hw/rtl/cfu_psi_stage.sv =====
// second and third stages: psi rounding, curl term, saturated inner sum
module cfu_psi_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cfu_pkg::prod_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output cfu_pkg::inner_type out_data
);

   logic v2_ff;
   logic v2_in;
   logic v3_ff;
   logic v3_in;
   logic rdy3;

   logic                                      is_e2_ff, is_e2_in;
   logic signed [cfu_pkg::DATA_WIDTH-1:0]     step2_ff, step2_in;
   logic signed [cfu_pkg::PROD_WIDTH-1:0]     old2_ff, old2_in;
   logic signed [cfu_pkg::DATA_WIDTH-1:0]     np1_ff, np1_in;
   logic signed [cfu_pkg::DATA_WIDTH-1:0]     np2_ff, np2_in;
   logic signed [cfu_pkg::KT_WIDTH-1:0]       kt_ff, kt_in;
   logic signed [cfu_pkg::WIDE_WIDTH-1:0]     kt_wide;
   logic signed [cfu_pkg::WIDE_WIDTH-1:0]     inner_wide;
   cfu_pkg::inner_type                        s3_ff, s3_in;

   assign rdy3     = !v3_ff || out_ready;
   assign in_ready = !v2_ff || rdy3;

   // stage 2
   always_comb begin
      v2_in    = v2_ff;
      is_e2_in = is_e2_ff;
      step2_in = step2_ff;
      old2_in  = old2_ff;
      np1_in   = np1_ff;
      np2_in   = np2_ff;
      kt_in    = kt_ff;
      kt_wide  = cfu_pkg::round_sum(in_data.ck1, in_data.ck2, 1'b1, cfu_pkg::COEF_SHIFT);
      if (in_ready) begin
         v2_in = in_valid;
      end
      if (in_ready && in_valid) begin
         is_e2_in = in_data.is_e;
         step2_in = in_data.step;
         old2_in  = in_data.old_prod;
         np1_in   = cfu_pkg::sat_q(cfu_pkg::round_sum(in_data.bp1, in_data.cc1, 1'b0,
                                                      cfu_pkg::COEF_SHIFT));
         np2_in   = cfu_pkg::sat_q(cfu_pkg::round_sum(in_data.bp2, in_data.cc2, 1'b0,
                                                      cfu_pkg::COEF_SHIFT));
         kt_in    = kt_wide[cfu_pkg::KT_WIDTH-1:0];
      end
   end

   // stage 3
   always_comb begin
      v3_in      = v3_ff;
      s3_in      = s3_ff;
      inner_wide = {{(cfu_pkg::WIDE_WIDTH-cfu_pkg::KT_WIDTH){kt_ff[cfu_pkg::KT_WIDTH-1]}}, kt_ff}
                 + {{(cfu_pkg::WIDE_WIDTH-cfu_pkg::DATA_WIDTH){np1_ff[cfu_pkg::DATA_WIDTH-1]}},
                    np1_ff}
                 - {{(cfu_pkg::WIDE_WIDTH-cfu_pkg::DATA_WIDTH){np2_ff[cfu_pkg::DATA_WIDTH-1]}},
                    np2_ff};
      if (rdy3) begin
         v3_in = v2_ff;
      end
      if (rdy3 && v2_ff) begin
         s3_in.is_e     = is_e2_ff;
         s3_in.step     = step2_ff;
         s3_in.old_prod = old2_ff;
         s3_in.inner    = cfu_pkg::sat_q(inner_wide);
         s3_in.np1      = np1_ff;
         s3_in.np2      = np2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      is_e2_ff <= is_e2_in;
      step2_ff <= step2_in;
      old2_ff  <= old2_in;
      np1_ff   <= np1_in;
      np2_ff   <= np2_in;
      kt_ff    <= kt_in;
      s3_ff    <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

// ===== hw/rtl/cfu_field_stage.sv =====
// fourth and fifth stages: step product, field rounding and output register
module cfu_field_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cfu_pkg::inner_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output cfu_pkg::rsp_type   out_data
);

   logic v4_ff;
   logic v4_in;
   logic v5_ff;
   logic v5_in;
   logic rdy5;

   logic                                  is_e4_ff, is_e4_in;
   logic signed [cfu_pkg::PROD_WIDTH-1:0] old4_ff, old4_in;
   logic signed [cfu_pkg::PROD_WIDTH-1:0] sp4_ff, sp4_in;
   logic signed [cfu_pkg::DATA_WIDTH-1:0] np1_4_ff, np1_4_in;
   logic signed [cfu_pkg::DATA_WIDTH-1:0] np2_4_ff, np2_4_in;
   cfu_pkg::rsp_type                      rsp_ff, rsp_in;

   assign rdy5     = !v5_ff || out_ready;
   assign in_ready = !v4_ff || rdy5;

   // stage 4
   always_comb begin
      v4_in    = v4_ff;
      is_e4_in = is_e4_ff;
      old4_in  = old4_ff;
      sp4_in   = sp4_ff;
      np1_4_in = np1_4_ff;
      np2_4_in = np2_4_ff;
      if (in_ready) begin
         v4_in = in_valid;
      end
      if (in_ready && in_valid) begin
         is_e4_in = in_data.is_e;
         old4_in  = in_data.old_prod;
         sp4_in   = $signed(in_data.step) * $signed(in_data.inner);
         np1_4_in = in_data.np1;
         np2_4_in = in_data.np2;
      end
   end

   // stage 5, subtract for h update
   always_comb begin
      v5_in  = v5_ff;
      rsp_in = rsp_ff;
      if (rdy5) begin
         v5_in = v4_ff;
      end
      if (rdy5 && v4_ff) begin
         rsp_in.new_value      = cfu_pkg::sat_q(cfu_pkg::round_sum(old4_ff, sp4_ff, !is_e4_ff,
                                                                    cfu_pkg::FIELD_SHIFT));
         rsp_in.new_psi_first  = np1_4_ff;
         rsp_in.new_psi_second = np2_4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
      is_e4_ff <= is_e4_in;
      old4_ff  <= old4_in;
      sp4_ff   <= sp4_in;
      np1_4_ff <= np1_4_in;
      np2_4_ff <= np2_4_in;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = v5_ff;
   assign out_data  = rsp_ff;

endmodule

// ===== hw/rtl/cpml_fdtd_cell_update_unit.sv =====
// top level of the cpml yee cell update unit
// Usage:
// One request carries one field component of one grid cell: old value, two
// partial curl terms, two psi values with their b, c and 1/kappa coefficients,
// and func (0 = h update, subtract; 1 = e update, add). One response returns
// the new field value and both new psi values, Q8.24 saturated.
// Requests and responses use valid/ready; the csr port writes e_scale,
// h_scale, e_step and h_step by index and must only be used while idle.
// The pipeline has five register stages: products, psi and curl rounding,
// inner sum, step product, field rounding into the output register.
// rsp_valid rises once a request has passed through every stage register in turn;
// throughput is one request per cycle while rsp_ready stays high, since every
// stage is a single register that takes a new request whenever it can pass one on.
// A stalled receiver holds the response in the output register; each stage
// keeps filling behind it until the pipeline is full, then req_ready drops.
// Nothing is lost or repeated under stalls.
// Synchronous reset empties all stages and sets all four registers to 1.0.
module cpml_fdtd_cell_update_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [cfu_pkg::DATA_WIDTH-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_old_value,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_curl_first,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_curl_second,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_psi_first,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_psi_second,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_decay_first,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_gain_first,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_decay_second,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_gain_second,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_inv_kappa_first,
   input  logic signed [cfu_pkg::DATA_WIDTH-1:0] req_inv_kappa_second,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cfu_pkg::DATA_WIDTH-1:0] rsp_new_value,
   output logic signed [cfu_pkg::DATA_WIDTH-1:0] rsp_new_psi_first,
   output logic signed [cfu_pkg::DATA_WIDTH-1:0] rsp_new_psi_second
);

   cfu_pkg::cfg_type   cfg;
   cfu_pkg::req_type   req;
   cfu_pkg::prod_type  prod;
   cfu_pkg::inner_type inner;
   cfu_pkg::rsp_type   rsp;
   logic prod_valid;
   logic prod_ready;
   logic inner_valid;
   logic inner_ready;

   always_comb begin
      req.func             = req_func;
      req.old_value        = req_old_value;
      req.curl_first       = req_curl_first;
      req.curl_second      = req_curl_second;
      req.psi_first        = req_psi_first;
      req.psi_second       = req_psi_second;
      req.decay_first      = req_decay_first;
      req.gain_first       = req_gain_first;
      req.decay_second     = req_decay_second;
      req.gain_second      = req_gain_second;
      req.inv_kappa_first  = req_inv_kappa_first;
      req.inv_kappa_second = req_inv_kappa_second;
   end

   cfu_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cfu_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod)
   );

   cfu_psi_stage u_psi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod),
      .out_valid (inner_valid),
      .out_ready (inner_ready),
      .out_data  (inner)
   );

   cfu_field_stage u_field (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (inner_valid),
      .in_ready  (inner_ready),
      .in_data   (inner),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp)
   );

   assign rsp_new_value      = rsp.new_value;
   assign rsp_new_psi_first  = rsp.new_psi_first;
   assign rsp_new_psi_second = rsp.new_psi_second;

endmodule

// ===== hw/rtl/cfu_checker.sv =====
// port-level checker for the cpml cell update unit and its bind
module cfu_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [cfu_pkg::DATA_WIDTH-1:0] rsp_new_value
);

   localparam logic [3:0] PIPE_DEPTH = 4'd5;

   logic [3:0] pending_ff;
   logic [3:0] pending_in;

   always_comb begin
      pending_in = pending_ff + {3'd0, req_valid && req_ready} - {3'd0, rsp_valid && rsp_ready};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 4'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no response without a request in flight
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without outstanding request");

   // never more requests in flight than stage registers
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PIPE_DEPTH)
      else $error("more requests in flight than pipeline stages");

   // empty pipeline always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 4'd0 |-> req_ready)
      else $error("request stalled while pipeline empty");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_value))
      else $error("stalled response dropped or changed");

endmodule

bind cpml_fdtd_cell_update_unit cfu_checker u_cfu_checker (.*);

// ===== dv/tb_top.sv =====
// self-checking testbench for the cpml cell update unit: directed table, then random requests
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int RANDOM_PER_PHASE = 110;
   localparam int PHASES = 5;

   localparam logic [31:0] ZERO   = 32'h0000_0000;
   localparam logic [31:0] ONE    = cfu_pkg::Q_ONE;
   localparam logic [31:0] HI     = cfu_pkg::Q_MAX;
   localparam logic [31:0] LO     = cfu_pkg::Q_MIN;
   localparam logic [31:0] M1     = 32'hffff_ffff;
   localparam logic [31:0] C_HALF = 32'h2000_0000;
   localparam logic [31:0] C_ONE  = 32'h4000_0000;

   typedef struct {
      cfu_pkg::req_type stim;
      bit               typed;
      cfu_pkg::rsp_type want;
   } vector_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   cfu_pkg::csr_index_type csr_index;
   logic [31:0]            csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   cfu_pkg::req_type       req_bus;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [31:0]     rsp_new_value;
   logic signed [31:0]     rsp_new_psi_first;
   logic signed [31:0]     rsp_new_psi_second;

   cfu_pkg::cfg_type field_cfg = '{cfu_pkg::Q_ONE, cfu_pkg::Q_ONE,
                                   cfu_pkg::Q_ONE, cfu_pkg::Q_ONE};
   cfu_pkg::rsp_type pending_updates[$];
   vector_row_type   directed_rows[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               burst_left = 0;

   cpml_fdtd_cell_update_unit dut (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_bus.func),
      .req_old_value        (req_bus.old_value),
      .req_curl_first       (req_bus.curl_first),
      .req_curl_second      (req_bus.curl_second),
      .req_psi_first        (req_bus.psi_first),
      .req_psi_second       (req_bus.psi_second),
      .req_decay_first      (req_bus.decay_first),
      .req_gain_first       (req_bus.gain_first),
      .req_decay_second     (req_bus.decay_second),
      .req_gain_second      (req_bus.gain_second),
      .req_inv_kappa_first  (req_bus.inv_kappa_first),
      .req_inv_kappa_second (req_bus.inv_kappa_second),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_new_value        (rsp_new_value),
      .rsp_new_psi_first    (rsp_new_psi_first),
      .rsp_new_psi_second   (rsp_new_psi_second)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [71:0] wide(input logic [31:0] v);
      return {{40{v[31]}}, v};
   endfunction

   function automatic logic signed [71:0] round_half_up(input logic signed [71:0] v,
                                                        input int unsigned sh);
      logic signed [71:0] half;
      logic signed [71:0] sum;
      half = 72'sd1 <<< (sh - 1);
      sum  = v + half;
      return sum >>> sh;
   endfunction

   function automatic logic [31:0] clamp_q(input logic signed [71:0] v);
      if (v > wide(cfu_pkg::Q_MAX)) begin
         return cfu_pkg::Q_MAX;
      end else if (v < wide(cfu_pkg::Q_MIN)) begin
         return cfu_pkg::Q_MIN;
      end
      return v[31:0];
   endfunction

   function automatic cfu_pkg::rsp_type cell_update(input cfu_pkg::req_type r);
      logic               is_e;
      logic signed [71:0] scale;
      logic signed [71:0] step;
      logic signed [71:0] curl_term;
      logic signed [71:0] acc;
      logic [31:0]        inner;
      cfu_pkg::rsp_type   o;
      is_e  = (r.func == cfu_pkg::FUNC_E_UPDATE);
      scale = wide(is_e ? field_cfg.e_scale : field_cfg.h_scale);
      step  = wide(is_e ? field_cfg.e_step : field_cfg.h_step);
      o.new_psi_first = clamp_q(round_half_up(wide(r.decay_first) * wide(r.psi_first)
                                              + wide(r.gain_first) * wide(r.curl_first), 30));
      o.new_psi_second = clamp_q(round_half_up(wide(r.decay_second) * wide(r.psi_second)
                                               + wide(r.gain_second) * wide(r.curl_second), 30));
      curl_term = round_half_up(wide(r.curl_first) * wide(r.inv_kappa_first)
                                - wide(r.curl_second) * wide(r.inv_kappa_second), 30);
      inner = clamp_q(curl_term + wide(o.new_psi_first) - wide(o.new_psi_second));
      if (is_e) begin
         acc = scale * wide(r.old_value) + step * wide(inner);
      end else begin
         acc = scale * wide(r.old_value) - step * wide(inner);
      end
      o.new_value = clamp_q(round_half_up(acc, 24));
      return o;
   endfunction

   // mix of full-range words, corner values and small magnitudes
   function automatic logic [31:0] pick_operand(input int unsigned top);
      logic [31:0] mag;
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 5))
               0: return HI;
               1: return LO;
               2: return ZERO;
               3: return 32'h0000_0001;
               4: return M1;
               default: return ONE;
            endcase
         end
         default: begin
            mag = $urandom & ((32'd1 << $urandom_range(1, top)) - 32'd1);
            return ($urandom_range(0, 1) != 0) ? -mag : mag;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic load_config(input cfu_pkg::cfg_type c);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= cfu_pkg::csr_index_type'(i);
         case (cfu_pkg::csr_index_type'(i))
            cfu_pkg::CSR_E_SCALE: csr_wdata <= c.e_scale;
            cfu_pkg::CSR_H_SCALE: csr_wdata <= c.h_scale;
            cfu_pkg::CSR_E_STEP:  csr_wdata <= c.e_step;
            default:              csr_wdata <= c.h_step;
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
      field_cfg = c;
   endtask

   task automatic issue_request(input cfu_pkg::req_type stim, input bit typed,
                                input cfu_pkg::rsp_type want);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_bus   <= stim;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_updates.push_back(typed ? want : cell_update(stim));
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : receive_results
      cfu_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case ((cycle_count / 97) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (cycle_count % 5) == 0;
            default: rsp_ready <= (cycle_count % 23) > 17;
         endcase
         if (rsp_valid && rsp_ready) begin
            if (pending_updates.size() == 0) begin
               report_mismatch("response with no request pending", rsp_new_value, ZERO);
            end else begin
               want = pending_updates.pop_front();
               if (rsp_new_value !== want.new_value) begin
                  report_mismatch("new_value", rsp_new_value, want.new_value);
               end
               if (rsp_new_psi_first !== want.new_psi_first) begin
                  report_mismatch("new_psi_first", rsp_new_psi_first, want.new_psi_first);
               end
               if (rsp_new_psi_second !== want.new_psi_second) begin
                  report_mismatch("new_psi_second", rsp_new_psi_second, want.new_psi_second);
               end
            end
         end
      end
   end

   initial begin
      cfu_pkg::req_type stim;
      cfu_pkg::cfg_type setting;

      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= cfu_pkg::CSR_E_SCALE;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_bus   <= '0;

      // fields: func, old, curl1, curl2, psi1, psi2, b1, c1, b2, c2, 1/kappa1, 1/kappa2
      directed_rows.push_back('{'{cfu_pkg::FUNC_H_UPDATE, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ONE, ZERO, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{ONE, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_H_UPDATE, HI, ZERO, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{HI, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, LO, ZERO, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{LO, ZERO, ZERO}});
      // psi ties round toward plus infinity
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, ZERO, ZERO, 32'h1, ZERO, C_HALF,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{32'h1, 32'h1, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_H_UPDATE, ZERO, ZERO, ZERO, 32'h1, ZERO, C_HALF,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{M1, 32'h1, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, ZERO, ZERO, M1, ZERO, C_HALF,
                                  ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, ZERO, ZERO, ZERO, 32'h1, ZERO,
                                  ZERO, C_HALF, ZERO, ZERO, ZERO}, 1'b1, '{M1, ZERO, 32'h1}});
      // curl term ties
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, 32'h1, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, C_HALF, ZERO}, 1'b1, '{32'h1, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, M1, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, C_HALF, ZERO}, 1'b1, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_H_UPDATE, ONE, ONE, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, C_ONE, ZERO}, 1'b1, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ONE, ONE, ZERO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, C_ONE, ZERO}, 1'b1,
                                '{32'h0200_0000, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, ONE, ZERO, ZERO, ZERO, ZERO,
                                  C_ONE, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{ONE, ONE, ZERO}});
      // saturation of psi, curl term and inner sum
      directed_rows.push_back('{'{cfu_pkg::FUNC_H_UPDATE, ZERO, ZERO, ZERO, HI, HI, HI,
                                  ZERO, LO, ZERO, ZERO, ZERO}, 1'b0, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, ZERO, HI, LO, ZERO, ZERO, ZERO,
                                  ZERO, ZERO, ZERO, HI, HI}, 1'b0, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_H_UPDATE, ZERO, LO, HI, ZERO, ZERO, ZERO,
                                  LO, ZERO, ZERO, LO, LO}, 1'b0, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, HI, HI, HI, HI, HI, HI,
                                  HI, HI, HI, HI, HI}, 1'b0, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_H_UPDATE, LO, LO, LO, LO, LO, LO,
                                  LO, LO, LO, LO, LO}, 1'b0, '{ZERO, ZERO, ZERO}});
      directed_rows.push_back('{'{cfu_pkg::FUNC_E_UPDATE, M1, M1, M1, M1, M1, M1,
                                  M1, M1, M1, M1, M1}, 1'b0, '{ZERO, ZERO, ZERO}});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            req_valid <= 1'b0;
            while (pending_updates.size() != 0) @(posedge clock);
            case (phase)
               1: setting = '{LO, HI, HI, LO};
               2: setting = '{ZERO, ZERO, cfu_pkg::Q_ONE, -cfu_pkg::Q_ONE};
               default: setting = '{pick_operand(28), pick_operand(28),
                                    pick_operand(28), pick_operand(28)};
            endcase
            load_config(setting);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            stim.func             = 1'($urandom_range(0, 1));
            stim.old_value        = pick_operand(28);
            stim.curl_first       = pick_operand(28);
            stim.curl_second      = pick_operand(28);
            stim.psi_first        = pick_operand(28);
            stim.psi_second       = pick_operand(28);
            stim.decay_first      = pick_operand(30);
            stim.gain_first       = pick_operand(30);
            stim.decay_second     = pick_operand(30);
            stim.gain_second      = pick_operand(30);
            stim.inv_kappa_first  = pick_operand(30);
            stim.inv_kappa_second = pick_operand(30);
            issue_request(stim, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/cfu_pkg.sv
hw/rtl/cfu_csr_regs.sv
hw/rtl/cfu_product_stage.sv
hw/rtl/cfu_psi_stage.sv
hw/rtl/cfu_field_stage.sv
hw/rtl/cpml_fdtd_cell_update_unit.sv
hw/rtl/cfu_checker.sv
dv/tb_top.sv
